// ===== hdl/unicode_name_validator_assert.svh =====
// Assertion macros for the name validator.
`ifndef UNICODE_NAME_VALIDATOR_ASSERT_SVH
`define UNICODE_NAME_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UNV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/unv_pkg.sv =====
`timescale 1ns / 1ps

package unv_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 21;
  localparam int unsigned CountW = 3;

  localparam logic [CharW-1:0]  PrefixChar   = 8'h75;  // 'u'
  localparam logic [CharW-1:0]  SepChar      = 8'h5F;  // '_'
  localparam logic [ValueW-1:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [ValueW-1:0] SurrLow      = 21'h00D800;
  localparam logic [ValueW-1:0] SurrHigh     = 21'h00DFFF;
  localparam logic [ValueW-1:0] BmpMax       = 21'h00FFFF;
  localparam logic [CountW-1:0] BmpDigits    = 3'd4;
  localparam logic [CountW-1:0] CountMax     = 3'd7;

  // Per-name scan state
  typedef struct packed {
    logic              seen_prefix;
    logic              failed;
    logic [ValueW-1:0] group_value;
    logic [CountW-1:0] digit_count;
    logic              leading_zero;
  } scan_t;

  localparam scan_t ScanReset = '{
    seen_prefix:  1'b0,
    failed:       1'b0,
    group_value:  '0,
    digit_count:  '0,
    leading_zero: 1'b0
  };

endpackage

// ===== hdl/unv_step.sv =====
`timescale 1ns / 1ps

// One byte of the name applied to the scan state.
module unv_step (
  input  unv_pkg::scan_t                 cur,
  input  logic [unv_pkg::CharW-1:0]      char_code,
  input  logic                           is_last,
  output unv_pkg::scan_t                 nxt,
  output logic                           valid_res
);

  // A finished group is non-empty, not a surrogate, and has the right digits
  function automatic logic group_ok(unv_pkg::scan_t s);
    logic ok;
    ok = 1'b1;
    if (s.digit_count == '0) begin
      ok = 1'b0;
    end else if (s.group_value >= unv_pkg::SurrLow && s.group_value <= unv_pkg::SurrHigh) begin
      ok = 1'b0;
    end else if (s.group_value > unv_pkg::BmpMax) begin
      ok = !s.leading_zero;
    end else begin
      ok = (s.digit_count == unv_pkg::BmpDigits);
    end
    return ok;
  endfunction

  logic                         is_digit;
  logic [3:0]                   dval;
  logic [unv_pkg::ValueW+3:0]   shifted;
  unv_pkg::scan_t               after;

  // Uppercase hex decode
  always_comb begin
    is_digit = 1'b0;
    dval     = '0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      is_digit = 1'b1;
      dval     = 4'(char_code - 8'h30);
    end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
      is_digit = 1'b1;
      dval     = 4'(char_code - 8'h37);
    end
  end

  assign shifted = {cur.group_value, 4'b0000} + {{unv_pkg::ValueW{1'b0}}, dval};

  // State after this byte
  always_comb begin
    after = cur;
    if (!cur.seen_prefix) begin
      after.seen_prefix = 1'b1;
      if (char_code != unv_pkg::PrefixChar) after.failed = 1'b1;
    end else if (char_code == unv_pkg::SepChar) begin
      if (!group_ok(cur)) after.failed = 1'b1;
      after.group_value  = '0;
      after.digit_count  = '0;
      after.leading_zero = 1'b0;
    end else if (!is_digit) begin
      after.failed = 1'b1;
    end else begin
      if (cur.digit_count == '0) after.leading_zero = (dval == 4'd0);
      if (shifted > {4'b0000, unv_pkg::MaxCodePoint}) after.failed = 1'b1;
      after.group_value = shifted[unv_pkg::ValueW-1:0];
      if (cur.digit_count != unv_pkg::CountMax) after.digit_count = cur.digit_count + 3'd1;
    end
  end

  // Final verdict on the last byte, then back to reset
  assign valid_res = !after.failed && group_ok(after);
  assign nxt       = is_last ? unv_pkg::ScanReset : after;

endmodule

// ===== hdl/unicode_name_validator.sv =====
`timescale 1ns / 1ps

// Channel | Signals                          | Item
// --------+----------------------------------+-----------------------------
// in      | in_valid, in_ready, char_code,   | one byte of the name,
//         | is_last                          | is_last on the final byte
// out     | out_valid, out_ready, valid_res  | one verdict per name
//
// One byte per cycle unless a last byte stalls; scan updates once per byte.
// out_valid is registered as the last byte leaves the input register.
// rst (synchronous) clears the input stage, the scan state and the result.
// A stalled result blocks only a held last byte; other bytes keep flowing.

module unicode_name_validator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [unv_pkg::CharW-1:0]  char_code,
  input  logic                       is_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       valid_res
);

`include "unicode_name_validator_assert.svh"

  logic                       s1_valid;
  logic [unv_pkg::CharW-1:0]  s1_char;
  logic                       s1_last;
  logic                       advance;
  logic                       last_done;
  logic                       out_free;
  logic                       verdict;
  unv_pkg::scan_t             scan;
  unv_pkg::scan_t             scan_next;

  // Handshake: a held byte moves on unless it is last and the result is full
  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && (!s1_last || out_free);
  assign last_done = advance && s1_last;
  assign in_ready  = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_char <= char_code;
      s1_last <= is_last;
    end
  end

  unv_step u_step (
    .cur       (scan),
    .char_code (s1_char),
    .is_last   (s1_last),
    .nxt       (scan_next),
    .valid_res (verdict)
  );

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= unv_pkg::ScanReset;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (last_done) begin
      valid_res <= verdict;
    end
  end

  // Checks
  `UNV_ASSERT_NEXT(a_reset_after_last, last_done, scan == unv_pkg::ScanReset, "scan not cleared")
  `UNV_ASSERT_NOW(a_idle_state_clean, !scan.seen_prefix, scan == unv_pkg::ScanReset, "dirty idle")
  `UNV_ASSERT_NOW(a_result_from_last, $rose(out_valid), $past(last_done), "result without last")
  `UNV_ASSERT_NOW(a_no_overwrite, last_done, out_free, "result overwritten while held")

endmodule
